// ----- rtl/core/pcr_pkg.sv -----
`timescale 1ns / 1ps

package pcr_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int Q24_W      = 24;
    localparam int U16_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int IN_USE_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CONTACT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_USE = 1'b1;

    localparam logic [U16_W-1:0] GAIN_RESET = 16'd49152;
    localparam logic [U16_W-1:0] ELAST_ONE  = 16'd32768;

    // Divider: signed numerator, unsigned divisor, bounded quotient
    localparam int DIV_NW       = 43;
    localparam int DEN_W        = 17;
    localparam int QUO_W        = 26;
    localparam int DIV_Q_NARROW = 18;
    localparam int DIV_Q_WIDE   = 26;

    // Square root: radicand below the squared radius sum
    localparam int SQ_IN_W = 34;
    localparam int ROOT_W  = 17;

    localparam int ENTRY_W = 4 * Q24_W + 3 * U16_W;

    typedef struct packed {
        logic signed [Q24_W-1:0] pos_x;
        logic signed [Q24_W-1:0] pos_y;
        logic signed [Q24_W-1:0] vel_x;
        logic signed [Q24_W-1:0] vel_y;
        logic [U16_W-1:0]        radius;
        logic [U16_W-1:0]        mass;
        logic [U16_W-1:0]        elast;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [Q24_W-1:0] pos_x;
        logic signed [Q24_W-1:0] pos_y;
        logic signed [Q24_W-1:0] vel_x;
        logic signed [Q24_W-1:0] vel_y;
    } t_result;

    // Clamp to 24 bit signed
    function automatic logic signed [Q24_W-1:0] sat24(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd8388607;
        lo = -40'sd8388608;
        if (v > hi) begin
            return 24'sh7FFFFF;
        end else if (v < lo) begin
            return 24'sh800000;
        end
        return v[Q24_W-1:0];
    endfunction

    // Arithmetic right shift, rounded to nearest, ties away from zero
    function automatic logic signed [39:0] round_shift(input logic signed [63:0] x,
                                                       input logic [4:0] sh);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? 64'(-x) : 64'(x);
        q   = (mag + (64'd1 << (sh - 5'd1))) >> sh;
        return x[63] ? -40'(q) : 40'(q);
    endfunction

endpackage

// ----- rtl/core/pcr_if.sv -----
`timescale 1ns / 1ps

// Command channel
interface pcr_in_if;
    import pcr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic signed [Q24_W-1:0] pos_x;
    logic signed [Q24_W-1:0] pos_y;
    logic signed [Q24_W-1:0] vel_x;
    logic signed [Q24_W-1:0] vel_y;
    logic [U16_W-1:0]        radius;
    logic [U16_W-1:0]        mass;
    logic [U16_W-1:0]        elasticity;

    modport source (output valid, cmd, index_a, index_b, pos_x, pos_y, vel_x, vel_y,
                    radius, mass, elasticity, input ready);
    modport sink   (input valid, cmd, index_a, index_b, pos_x, pos_y, vel_x, vel_y,
                    radius, mass, elasticity, output ready);
endinterface

// Result channel
interface pcr_out_if;
    import pcr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [Q24_W-1:0] out_pos_x;
    logic signed [Q24_W-1:0] out_pos_y;
    logic signed [Q24_W-1:0] out_vel_x;
    logic signed [Q24_W-1:0] out_vel_y;

    modport source (output valid, status, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                    input ready);
    modport sink   (input valid, status, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                    output ready);
endinterface

// ----- rtl/core/pcr_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read
module pcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pcr_isqrt.sv -----
`timescale 1ns / 1ps

// Integer square root, floor, one bit of result per cycle
module pcr_isqrt
    import pcr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SQ_IN_W-1:0] i_radicand,
    output logic               o_done,
    output logic [ROOT_W-1:0]  o_root
);

    logic                 r_busy;
    logic                 r_done;
    logic [SQ_IN_W:0]     r_rem;
    logic [SQ_IN_W:0]     r_res;
    logic [SQ_IN_W:0]     r_bit;
    logic [SQ_IN_W:0]     w_trial;

    assign w_trial = r_res + r_bit;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Digit-by-digit step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (SQ_IN_W + 1)'(i_radicand);
            r_res <= '0;
            r_bit <= (SQ_IN_W + 1)'(1) << (SQ_IN_W - 2);
        end else if (r_busy) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("root done without a run");

endmodule

// ----- rtl/core/pcr_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, rounded to nearest, ties away from zero.
// Only the quotient bits that can be nonzero are iterated.
module pcr_div
    import pcr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIV_NW-1:0] i_num,
    input  logic [DEN_W-1:0]         i_den,
    input  logic                     i_wide,
    output logic                     o_done,
    output logic signed [QUO_W:0]    o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_cnt;
    logic                 r_neg;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [DIV_NW-1:0]    r_sh;
    logic [QUO_W-1:0]     r_q;
    logic [DIV_NW-1:0]    w_mag;
    logic [DIV_NW-1:0]    w_sum;
    logic [DEN_W:0]       w_cand;
    logic                 w_ge;

    assign w_mag  = i_num[DIV_NW-1] ? DIV_NW'(-i_num) : DIV_NW'(i_num);
    assign w_sum  = w_mag + DIV_NW'(i_den >> 1);
    assign w_cand = {r_rem, r_sh[DIV_NW-1]};
    assign w_ge   = w_cand >= {1'b0, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: pre-shift skips the leading quotient bits known to be zero
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DIV_NW-1];
            r_den <= i_den;
            r_q   <= '0;
            if (i_wide) begin
                r_rem <= DEN_W'(w_sum >> DIV_Q_WIDE);
                r_sh  <= w_sum << (DIV_NW - DIV_Q_WIDE);
                r_cnt <= 5'(DIV_Q_WIDE);
            end else begin
                r_rem <= DEN_W'(w_sum >> DIV_Q_NARROW);
                r_sh  <= w_sum << (DIV_NW - DIV_Q_NARROW);
                r_cnt <= 5'(DIV_Q_NARROW);
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_cand - {1'b0, r_den}) : w_cand[DEN_W-1:0];
            r_sh  <= r_sh << 1;
            r_q   <= {r_q[QUO_W-2:0], w_ge};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -(QUO_W + 1)'(r_q) : (QUO_W + 1)'(r_q);

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");

endmodule

// ----- rtl/core/pairwise_collision_resolver_core.sv -----
`timescale 1ns / 1ps
// Throughput: one command at a time; the next is taken once the result is registered.
// Resolve time is set by the shared bit-serial divider (up to ten divisions) and the square root.
// Reset (synchronous, active low) clears control, gain to 0.75 and the in-use count to zero;
// the particle table holds no defined data until written.
module pairwise_collision_resolver_core
    import pcr_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcr_in_if.sink                i_req,
    pcr_out_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_PARTICLES);

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_WRITE = 6'd1;
    localparam logic [5:0] S_RDA   = 6'd2;
    localparam logic [5:0] S_RDB   = 6'd3;
    localparam logic [5:0] S_CAPB  = 6'd4;
    localparam logic [5:0] S_DIF   = 6'd5;
    localparam logic [5:0] S_MDX   = 6'd6;
    localparam logic [5:0] S_MDY   = 6'd7;
    localparam logic [5:0] S_MRS   = 6'd8;
    localparam logic [5:0] S_CMP   = 6'd9;
    localparam logic [5:0] S_SQRT  = 6'd10;
    localparam logic [5:0] S_MPEN  = 6'd11;
    localparam logic [5:0] S_T     = 6'd12;
    localparam logic [5:0] S_MTB   = 6'd13;
    localparam logic [5:0] S_DSA   = 6'd14;
    localparam logic [5:0] S_DSAW  = 6'd15;
    localparam logic [5:0] S_MTA   = 6'd16;
    localparam logic [5:0] S_DSB   = 6'd17;
    localparam logic [5:0] S_DSBW  = 6'd18;
    localparam logic [5:0] S_PMUL  = 6'd19;
    localparam logic [5:0] S_PDIV  = 6'd20;
    localparam logic [5:0] S_PDIVW = 6'd21;
    localparam logic [5:0] S_EMUL  = 6'd22;
    localparam logic [5:0] S_EGET  = 6'd23;
    localparam logic [5:0] S_VM1   = 6'd24;
    localparam logic [5:0] S_VM2   = 6'd25;
    localparam logic [5:0] S_VDIV  = 6'd26;
    localparam logic [5:0] S_VDIVW = 6'd27;
    localparam logic [5:0] S_VME   = 6'd28;
    localparam logic [5:0] S_VRND  = 6'd29;
    localparam logic [5:0] S_WBA   = 6'd30;
    localparam logic [5:0] S_WBB   = 6'd31;
    localparam logic [5:0] S_DONE  = 6'd32;

    // Control state
    logic [5:0]          r_state, n_state;
    logic [U16_W-1:0]    r_gain;
    logic [IN_USE_W-1:0] r_in_use;
    logic                r_o_valid;
    t_result             r_out;

    // Command and working registers
    logic [CMD_W-1:0]        r_cmd;
    logic [IDX_W-1:0]        r_ia, r_ib;
    t_entry                  r_wr;
    t_entry                  r_ent_a, r_ent_b;
    t_result                 r_res;
    logic signed [Q24_W:0]   r_dx, r_dy;
    logic [DEN_W-1:0]        r_rs, r_msum;
    logic [49:0]             r_d2;
    logic [ROOT_W-1:0]       r_dist;
    logic signed [17:0]      r_t, r_sa, r_sb;
    logic [30:0]             r_e;
    logic signed [DIV_NW-1:0] r_acc;
    logic signed [QUO_W:0]   r_w;
    logic [1:0]              r_job;
    logic signed [Q24_W-1:0] r_npos [4];
    logic signed [Q24_W-1:0] r_nvel [4];
    logic signed [63:0]      r_prod;

    logic                    w_acc_in;
    logic                    w_bad;
    logic                    w_ok_a, w_ok_b;
    logic signed [31:0]      m_a, m_b;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    t_entry                  ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    t_entry                  w_rd;
    logic                    div_start, div_wide, div_done;
    logic signed [DIV_NW-1:0] div_num;
    logic [DEN_W-1:0]        div_den;
    logic signed [QUO_W:0]   div_quot;
    logic                    sq_start, sq_done;
    logic [ROOT_W-1:0]       sq_root;
    logic signed [17:0]      w_pen;
    logic signed [Q24_W-1:0] w_va, w_vb;
    logic signed [17:0]      w_c1, w_c2;
    logic signed [Q24_W:0]   w_dk;
    logic signed [17:0]      w_s;
    logic signed [27:0]      w_pos_sum;

    assign w_acc_in = i_req.valid && i_req.ready;
    assign w_rd     = t_entry'(ram_rdata);

    // Index checks against the in-use count and the table depth
    assign w_ok_a = (IN_USE_W'(i_req.index_a) < r_in_use) &&
                    (32'(i_req.index_a) < MAX_PARTICLES);
    assign w_ok_b = (IN_USE_W'(i_req.index_b) < r_in_use) &&
                    (32'(i_req.index_b) < MAX_PARTICLES);
    assign w_bad  = !w_ok_a || (i_req.cmd == CMD_RESOLVE && !w_ok_b);

    assign w_pen = 18'({1'b0, r_dist}) - 18'({1'b0, r_rs});
    assign w_dk  = r_job[0] ? r_dy : r_dx;
    assign w_s   = r_job[1] ? r_sb : r_sa;
    assign w_va  = r_job[0] ? r_ent_a.vel_y : r_ent_a.vel_x;
    assign w_vb  = r_job[0] ? r_ent_b.vel_y : r_ent_b.vel_x;
    assign w_c1  = r_job[1] ? 18'({1'b0, r_ent_a.mass, 1'b0})
                            : 18'({2'b0, r_ent_a.mass}) - 18'({2'b0, r_ent_b.mass});
    assign w_c2  = r_job[1] ? 18'({2'b0, r_ent_b.mass}) - 18'({2'b0, r_ent_a.mass})
                            : 18'({1'b0, r_ent_b.mass, 1'b0});
    assign w_pos_sum = r_job[1] ? 28'(r_npos[r_job]) + 28'(div_quot)
                                : 28'(r_npos[r_job]) - 28'(div_quot);

    // Shared multiplier operand select, product registered every cycle
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_MDX:   begin m_a = 32'(r_dx); m_b = 32'(r_dx); end
            S_MDY:   begin m_a = 32'(r_dy); m_b = 32'(r_dy); end
            S_MRS:   begin m_a = 32'(r_rs); m_b = 32'(r_rs); end
            S_MPEN:  begin m_a = 32'(w_pen); m_b = 32'(r_gain); end
            S_MTB:   begin m_a = 32'(r_t); m_b = 32'(r_ent_b.mass); end
            S_MTA:   begin m_a = 32'(r_t); m_b = 32'(r_ent_a.mass); end
            S_PMUL:  begin m_a = 32'(w_dk); m_b = 32'(w_s); end
            S_EMUL:  begin m_a = 32'(r_ent_a.elast); m_b = 32'(r_ent_b.elast); end
            S_VM1:   begin m_a = 32'(w_va); m_b = 32'(w_c1); end
            S_VM2:   begin m_a = 32'(w_vb); m_b = 32'(w_c2); end
            S_VME:   begin m_a = 32'(r_w); m_b = 32'(r_e); end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // Divider and root requests
    always_comb begin
        div_start = 1'b0;
        div_wide  = 1'b0;
        div_num   = DIV_NW'(r_prod);
        div_den   = r_msum;
        case (r_state)
            S_DSA, S_DSB: begin
                div_start = 1'b1;
            end
            S_PDIV: begin
                div_start = 1'b1;
                div_den   = r_dist;
            end
            S_VDIV: begin
                div_start = 1'b1;
                div_wide  = 1'b1;
                div_num   = r_acc + DIV_NW'(r_prod);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sq_start = (r_state == S_CMP) && (r_d2 < 50'(r_prod[33:0])) && (r_msum != '0);

    // Table port control
    assign ram_we    = (r_state == S_WRITE) || (r_state == S_WBA) || (r_state == S_WBB);
    assign ram_waddr = (r_state == S_WBB) ? AW'(r_ib) : AW'(r_ia);
    assign ram_raddr = (r_state == S_RDA) ? AW'(r_ia) : AW'(r_ib);

    always_comb begin
        ram_wdata = r_wr;
        case (r_state)
            S_WBA: begin
                ram_wdata       = r_ent_a;
                ram_wdata.pos_x = r_npos[0];
                ram_wdata.pos_y = r_npos[1];
                ram_wdata.vel_x = r_nvel[0];
                ram_wdata.vel_y = r_nvel[1];
            end
            S_WBB: begin
                ram_wdata       = r_ent_b;
                ram_wdata.pos_x = r_npos[2];
                ram_wdata.pos_y = r_npos[3];
                ram_wdata.vel_x = r_nvel[2];
                ram_wdata.vel_y = r_nvel[3];
            end
            default: begin
                ram_wdata = r_wr;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    if (i_req.cmd != CMD_WRITE && i_req.cmd != CMD_READ &&
                        i_req.cmd != CMD_RESOLVE) begin
                        n_state = S_DONE;
                    end else if (w_bad) begin
                        n_state = S_DONE;
                    end else if (i_req.cmd == CMD_WRITE) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_RDA;
                    end
                end
            end
            S_WRITE: n_state = S_DONE;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = (r_cmd == CMD_RESOLVE && r_ia != r_ib) ? S_CAPB : S_DONE;
            S_CAPB:  n_state = S_DIF;
            S_DIF:   n_state = S_MDX;
            S_MDX:   n_state = S_MDY;
            S_MDY:   n_state = S_MRS;
            S_MRS:   n_state = S_CMP;
            S_CMP:   n_state = sq_start ? S_SQRT : S_DONE;
            S_SQRT:  n_state = sq_done ? S_MPEN : S_SQRT;
            S_MPEN:  n_state = S_T;
            S_T:     n_state = S_MTB;
            S_MTB:   n_state = S_DSA;
            S_DSA:   n_state = S_DSAW;
            S_DSAW:  n_state = div_done ? S_MTA : S_DSAW;
            S_MTA:   n_state = S_DSB;
            S_DSB:   n_state = S_DSBW;
            S_DSBW: begin
                if (div_done) begin
                    n_state = (r_dist != '0) ? S_PMUL : S_EMUL;
                end
            end
            S_PMUL:  n_state = S_PDIV;
            S_PDIV:  n_state = S_PDIVW;
            S_PDIVW: begin
                if (div_done) begin
                    n_state = (r_job == 2'd3) ? S_EMUL : S_PMUL;
                end
            end
            S_EMUL:  n_state = S_EGET;
            S_EGET:  n_state = (r_prod != '0) ? S_VM1 : S_WBA;
            S_VM1:   n_state = S_VM2;
            S_VM2:   n_state = S_VDIV;
            S_VDIV:  n_state = S_VDIVW;
            S_VDIVW: n_state = div_done ? S_VME : S_VDIVW;
            S_VME:   n_state = S_VRND;
            S_VRND:  n_state = (r_job == 2'd3) ? S_WBA : S_VM1;
            S_WBA:   n_state = S_WBB;
            S_WBB:   n_state = S_DONE;
            S_DONE:  n_state = (!r_o_valid || o_rsp.ready) ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers, configuration and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gain    <= GAIN_RESET;
            r_in_use  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN:   r_gain   <= i_cfg_data;
                    CFG_IN_USE: r_in_use <= i_cfg_data[IN_USE_W-1:0];
                    default:    r_gain   <= r_gain;
                endcase
            end
            if (r_state == S_DONE && (!r_o_valid || o_rsp.ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    r_cmd        <= i_req.cmd;
                    r_ia         <= i_req.index_a;
                    r_ib         <= i_req.index_b;
                    r_wr.pos_x   <= i_req.pos_x;
                    r_wr.pos_y   <= i_req.pos_y;
                    r_wr.vel_x   <= i_req.vel_x;
                    r_wr.vel_y   <= i_req.vel_y;
                    r_wr.radius  <= i_req.radius;
                    r_wr.mass    <= (i_req.mass == '0) ? 16'd1 : i_req.mass;
                    r_wr.elast   <= (i_req.elasticity > ELAST_ONE) ? ELAST_ONE
                                                                   : i_req.elasticity;
                    r_res        <= '{status: (w_bad && (i_req.cmd == CMD_WRITE ||
                                                         i_req.cmd == CMD_READ ||
                                                         i_req.cmd == CMD_RESOLVE))
                                              ? ST_BAD : ST_OK,
                                      default: '0};
                end
            end
            S_WRITE: begin
                r_res.pos_x <= r_wr.pos_x;
                r_res.pos_y <= r_wr.pos_y;
                r_res.vel_x <= r_wr.vel_x;
                r_res.vel_y <= r_wr.vel_y;
            end
            S_RDB: begin
                r_ent_a     <= w_rd;
                r_res.pos_x <= w_rd.pos_x;
                r_res.pos_y <= w_rd.pos_y;
                r_res.vel_x <= w_rd.vel_x;
                r_res.vel_y <= w_rd.vel_y;
            end
            S_CAPB: r_ent_b <= w_rd;
            S_DIF: begin
                r_dx   <= (Q24_W + 1)'(r_ent_a.pos_x) - (Q24_W + 1)'(r_ent_b.pos_x);
                r_dy   <= (Q24_W + 1)'(r_ent_a.pos_y) - (Q24_W + 1)'(r_ent_b.pos_y);
                r_rs   <= DEN_W'(r_ent_a.radius) + DEN_W'(r_ent_b.radius);
                r_msum <= DEN_W'(r_ent_a.mass) + DEN_W'(r_ent_b.mass);
            end
            S_MDY: r_d2 <= r_prod[49:0];
            S_MRS: r_d2 <= r_d2 + r_prod[49:0];
            S_CMP: begin
                r_npos[0] <= r_ent_a.pos_x;
                r_npos[1] <= r_ent_a.pos_y;
                r_npos[2] <= r_ent_b.pos_x;
                r_npos[3] <= r_ent_b.pos_y;
                r_nvel[0] <= r_ent_a.vel_x;
                r_nvel[1] <= r_ent_a.vel_y;
                r_nvel[2] <= r_ent_b.vel_x;
                r_nvel[3] <= r_ent_b.vel_y;
                r_job     <= 2'd0;
            end
            S_SQRT: begin
                if (sq_done) begin
                    r_dist <= sq_root;
                end
            end
            S_T: r_t <= 18'(round_shift(r_prod, 5'd17));
            S_DSAW: begin
                if (div_done) begin
                    r_sa <= 18'(div_quot);
                end
            end
            S_DSBW: begin
                if (div_done) begin
                    r_sb <= 18'(div_quot);
                end
            end
            S_PDIVW: begin
                if (div_done) begin
                    r_npos[r_job] <= sat24(40'(w_pos_sum));
                    r_job         <= r_job + 2'd1;
                end
            end
            S_EGET: r_e <= r_prod[30:0];
            S_VM2:  r_acc <= DIV_NW'(r_prod);
            S_VDIVW: begin
                if (div_done) begin
                    r_w <= div_quot;
                end
            end
            S_VRND: begin
                r_nvel[r_job] <= sat24(round_shift(r_prod, 5'd30));
                r_job         <= r_job + 2'd1;
            end
            S_WBB: begin
                r_res.status <= ST_CONTACT;
                r_res.pos_x  <= r_npos[0];
                r_res.pos_y  <= r_npos[1];
                r_res.vel_x  <= r_nvel[0];
                r_res.vel_y  <= r_nvel[1];
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_job <= r_job;
            end
        endcase
    end

    // Output
    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.out_pos_x = r_out.pos_x;
    assign o_rsp.out_pos_y = r_out.pos_y;
    assign o_rsp.out_vel_x = r_out.vel_x;
    assign o_rsp.out_vel_y = r_out.vel_y;

    pcr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_wide  (div_wide),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    pcr_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_d2[SQ_IN_W-1:0]),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !ram_we)
        else $error("table written outside a command");

    a_div_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DSAW || r_state == S_DSBW ||
                      r_state == S_PDIVW || r_state == S_VDIVW))
        else $error("quotient arrived outside a wait state");

    a_root_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQRT)) else $error("root arrived outside its wait");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_BAD) |->
        (o_rsp.out_pos_x == '0 && o_rsp.out_vel_y == '0))
        else $error("bad index result carries data");

endmodule
